@@ rtl/rbi_pkg.sv @@
// Shared types and constants for the ray/box intersection pipeline.
// No dependencies; every other file in rtl/ except rbi_if.sv refers to this package by scoped names.
`default_nettype none

package rbi_pkg;

    // One quotient bit is resolved per divider stage.
    localparam int DIV_STEPS = 31;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // Per-axis divider stage contents.
    typedef struct packed {
        logic [30:0] half;
        logic [31:0] org;
        logic [31:0] dir;
        logic        cand;
        logic        dzero;
        logic        tneg;
        logic        ovf;
        logic [31:0] mag;
        logic [31:0] dmag;
        logic [30:0] rem;
        logic [30:0] low;
        logic [30:0] q;
    } div_stage_t;

    // What one axis lane hands to the resolve stages.
    typedef struct packed {
        logic [30:0] half;
        logic [31:0] org;
        logic [31:0] dir;
        logic        cand;
        logic        dzero;
        logic        tnn;
        logic [30:0] t;
    } lane_out_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] hit_x;
        logic [31:0] hit_y;
        logic [31:0] hit_z;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/rbi_if.sv @@
// Valid/ready channel interfaces for the ray input and the hit result.
// No dependencies.
`default_nettype none

interface rbi_ray_if;
    logic        valid;
    logic        ready;
    logic [30:0] half_x;
    logic [30:0] half_y;
    logic [30:0] half_z;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [31:0] dir_z;

    modport source (
        output valid, half_x, half_y, half_z, origin_x, origin_y, origin_z,
               dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, half_x, half_y, half_z, origin_x, origin_y, origin_z,
               dir_x, dir_y, dir_z,
        output ready
    );
endinterface

interface rbi_hit_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] hit_x;
    logic [31:0] hit_y;
    logic [31:0] hit_z;

    modport source (output valid, hit, hit_x, hit_y, hit_z, input ready);
    modport sink (input valid, hit, hit_x, hit_y, hit_z, output ready);
endinterface

`default_nettype wire

@@ rtl/rbi_slab_lane.sv @@
// One axis lane: slab test followed by a pipelined restoring divider for t.
// Depends on rbi_pkg.
`default_nettype none

module rbi_slab_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [30:0]        half,
    input  wire logic [31:0]        org,
    input  wire logic [31:0]        dir,
    output logic                    out_valid,
    output rbi_pkg::lane_out_t      out
);

    localparam int NW    = 32 + FRAC_BITS;
    localparam int DEPTH = rbi_pkg::DIV_STEPS + 2;

    rbi_pkg::div_stage_t stage_reg  [DEPTH];
    rbi_pkg::div_stage_t stage_next [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [DEPTH-1:0]    valid_next;

    logic signed [32:0] org_w;
    logic signed [32:0] half_w;
    logic signed [32:0] mag_below;
    logic signed [32:0] mag_above;
    logic               below;
    logic               above;
    logic [NW-1:0]      num;
    logic [FRAC_BITS:0] hi;
    logic [31:0]        trial;
    logic               ge;

    always_comb
    begin
        org_w     = $signed({org[31], org});
        half_w    = $signed({2'b00, half});
        below     = org_w < -half_w;
        above     = org_w > half_w;
        mag_below = -half_w - org_w;
        mag_above = org_w - half_w;

        stage_next[0]       = '0;
        stage_next[0].half  = half;
        stage_next[0].org   = org;
        stage_next[0].dir   = dir;
        stage_next[0].cand  = below | above;
        stage_next[0].dzero = (dir == '0);
        // The numerator is negative only when the origin is above the slab.
        stage_next[0].tneg  = above ^ dir[31];
        stage_next[0].mag   = below ? mag_below[31:0] : mag_above[31:0];
        stage_next[0].dmag  = dir[31] ? 32'(-dir) : dir;

        // Quotients of 2^31 and above saturate; the top bits decide that at once.
        num                 = {stage_reg[0].mag, {FRAC_BITS{1'b0}}};
        hi                  = num[NW-1:31];
        stage_next[1]       = stage_reg[0];
        stage_next[1].ovf   = 32'(hi) >= stage_reg[0].dmag;
        stage_next[1].rem   = stage_next[1].ovf ? '0 : 31'(hi);
        stage_next[1].low   = num[30:0];
        stage_next[1].q     = '0;

        trial = '0;
        ge    = 1'b0;
        for (int k = 2; k < DEPTH; k++)
        begin
            trial             = {stage_reg[k-1].rem, stage_reg[k-1].low[30]};
            ge                = trial >= stage_reg[k-1].dmag;
            stage_next[k]     = stage_reg[k-1];
            stage_next[k].rem = ge ? 31'(trial - stage_reg[k-1].dmag) : trial[30:0];
            stage_next[k].q   = {stage_reg[k-1].q[29:0], ge};
            stage_next[k].low = {stage_reg[k-1].low[29:0], 1'b0};
        end

        valid_next = {valid_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    always_comb
    begin
        out_valid = valid_reg[DEPTH-1];
        out.half  = stage_reg[DEPTH-1].half;
        out.org   = stage_reg[DEPTH-1].org;
        out.dir   = stage_reg[DEPTH-1].dir;
        out.cand  = stage_reg[DEPTH-1].cand;
        out.dzero = stage_reg[DEPTH-1].dzero;
        out.tnn   = stage_reg[DEPTH-1].cand & ~stage_reg[DEPTH-1].tneg
                    & ~stage_reg[DEPTH-1].dzero;
        out.t     = stage_reg[DEPTH-1].ovf ? 31'h7FFF_FFFF : stage_reg[DEPTH-1].q;
    end

endmodule

`default_nettype wire

@@ rtl/rbi_resolve.sv @@
// Picks the entry axis, projects the ray onto the other two axes and checks them.
// Depends on rbi_pkg; fed by three rbi_slab_lane instances.
`default_nettype none

module rbi_resolve #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  rbi_pkg::lane_out_t      lx,
    input  rbi_pkg::lane_out_t      ly,
    input  rbi_pkg::lane_out_t      lz,
    output logic                    out_valid,
    output rbi_pkg::result_t        out
);

    localparam int NST = 4;

    typedef struct packed {
        logic [1:0]        w;
        logic [30:0]       tw;
        logic              in_box;
        logic              miss;
        logic [2:0][30:0]  half;
        logic [2:0][31:0]  org;
        logic [2:0][31:0]  dir;
        logic [2:0][63:0]  prod;
        logic [2:0][31:0]  val;
    } rs_stage_t;

    rs_stage_t      st_reg  [NST];
    rs_stage_t      st_next [NST];
    logic [NST-1:0] valid_reg;

    rbi_pkg::lane_out_t ln [3];
    logic signed [31:0] tv [3];
    logic signed [31:0] tb;
    logic               any_zero;
    logic signed [64:0] full_prod;
    logic signed [63:0] shifted;
    logic signed [32:0] sum;
    logic signed [33:0] neg_chk;
    logic [2:0]         ok;
    logic [2:0][31:0]   coord;

    always_comb
    begin
        ln[0] = lx;
        ln[1] = ly;
        ln[2] = lz;

        // Stage 0: choose the axis with the largest t; ties keep the earlier axis.
        st_next[0] = '0;
        any_zero   = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            tv[a]              = ln[a].tnn ? $signed({1'b0, ln[a].t}) : -32'sd1;
            any_zero           = any_zero | (ln[a].cand & ln[a].dzero);
            st_next[0].half[a] = ln[a].half;
            st_next[0].org[a]  = ln[a].org;
            st_next[0].dir[a]  = ln[a].dir;
        end
        st_next[0].w = rbi_pkg::AXIS_X;
        tb           = tv[0];
        if (tv[1] > tb)
        begin
            st_next[0].w = rbi_pkg::AXIS_Y;
            tb           = tv[1];
        end
        if (tv[2] > tb)
        begin
            st_next[0].w = rbi_pkg::AXIS_Z;
            tb           = tv[2];
        end
        st_next[0].in_box = ~(ln[0].cand | ln[1].cand | ln[2].cand);
        st_next[0].miss   = ~st_next[0].in_box & (any_zero | tb[31]);
        st_next[0].tw     = tb[30:0];

        // Stage 1: t times direction on every axis.
        st_next[1] = st_reg[0];
        full_prod  = '0;
        for (int a = 0; a < 3; a++)
        begin
            full_prod          = $signed({1'b0, st_reg[0].tw}) * $signed(st_reg[0].dir[a]);
            st_next[1].prod[a] = full_prod[63:0];
        end

        // Stage 2: floor shift and saturate the product.
        st_next[2] = st_reg[1];
        shifted    = '0;
        for (int a = 0; a < 3; a++)
        begin
            shifted = $signed(st_reg[1].prod[a]) >>> FRAC_BITS;
            if ((shifted[63:31] == '0) || (shifted[63:31] == '1))
            begin
                st_next[2].val[a] = shifted[31:0];
            end
            else
            begin
                st_next[2].val[a] = shifted[63] ? rbi_pkg::SAT_MIN : rbi_pkg::SAT_MAX;
            end
        end

        // Stage 3: add the origin with saturation.
        st_next[3] = st_reg[2];
        sum        = '0;
        for (int a = 0; a < 3; a++)
        begin
            sum = $signed({st_reg[2].org[a][31], st_reg[2].org[a]})
                  + $signed({st_reg[2].val[a][31], st_reg[2].val[a]});
            if (sum[32] != sum[31])
            begin
                st_next[3].val[a] = sum[32] ? rbi_pkg::SAT_MIN : rbi_pkg::SAT_MAX;
            end
            else
            begin
                st_next[3].val[a] = sum[31:0];
            end
        end

        // Output: extent check and assembly of the entry point.
        neg_chk = '0;
        for (int a = 0; a < 3; a++)
        begin
            neg_chk = $signed({3'b000, st_reg[3].half[a]})
                      + $signed({{2{st_reg[3].val[a][31]}}, st_reg[3].val[a]});
            ok[a]   = st_reg[3].val[a][31] ? ~neg_chk[33]
                                           : (st_reg[3].val[a][30:0] <= st_reg[3].half[a]);
            if (st_reg[3].in_box)
            begin
                coord[a] = st_reg[3].org[a];
            end
            else if (st_reg[3].w == 2'(a))
            begin
                coord[a] = st_reg[3].org[a][31] ? 32'(-{1'b0, st_reg[3].half[a]})
                                                : {1'b0, st_reg[3].half[a]};
            end
            else
            begin
                coord[a] = st_reg[3].val[a];
            end
        end

        out.hit = ~st_reg[3].miss
                  & (st_reg[3].in_box
                     | ((st_reg[3].w == rbi_pkg::AXIS_X | ok[0])
                        & (st_reg[3].w == rbi_pkg::AXIS_Y | ok[1])
                        & (st_reg[3].w == rbi_pkg::AXIS_Z | ok[2])));
        out.hit_x = out.hit ? coord[0] : '0;
        out.hit_y = out.hit ? coord[1] : '0;
        out.hit_z = out.hit ? coord[2] : '0;
        out_valid = valid_reg[NST-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NST; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/ray_box_intersect_unit.sv @@
// Ray against an origin-centered axis-aligned box, slab method, signed fixed point with
// FRAC_BITS fraction bits. One ray is taken every cycle while ray.ready is high, and
// each gives one result, in order, through 33 stages per axis for the slab test and a
// restoring divider that resolves one quotient bit per stage, 4 stages to pick the entry
// axis, multiply, saturate and add, and the output register. A second output entry
// lets the pipeline keep taking rays while one result waits; ray.ready drops only
// while both entries are full.
// Depends on rbi_pkg, rbi_if, rbi_slab_lane and rbi_resolve.
`default_nettype none

module ray_box_intersect_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rbi_ray_if.sink    ray,
    rbi_hit_if.source  result
);

    logic                 en;
    logic [2:0]           lane_valid;
    rbi_pkg::lane_out_t   lane_out [3];
    logic                 res_valid;
    rbi_pkg::result_t     res;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    rbi_pkg::result_t     out_data_reg;
    rbi_pkg::result_t     out_data_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    rbi_pkg::result_t     skid_data_reg;
    rbi_pkg::result_t     skid_data_next;
    logic                 arrive;

    assign en        = ~skid_valid_reg;
    assign ray.ready = en;

    rbi_slab_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ray.valid),
        .half      (ray.half_x),
        .org       (ray.origin_x),
        .dir       (ray.dir_x),
        .out_valid (lane_valid[0]),
        .out       (lane_out[0])
    );

    rbi_slab_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ray.valid),
        .half      (ray.half_y),
        .org       (ray.origin_y),
        .dir       (ray.dir_y),
        .out_valid (lane_valid[1]),
        .out       (lane_out[1])
    );

    rbi_slab_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ray.valid),
        .half      (ray.half_z),
        .org       (ray.origin_z),
        .dir       (ray.dir_z),
        .out_valid (lane_valid[2]),
        .out       (lane_out[2])
    );

    rbi_resolve #(.FRAC_BITS(FRAC_BITS)) u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (&lane_valid),
        .lx        (lane_out[0]),
        .ly        (lane_out[1]),
        .lz        (lane_out[2]),
        .out_valid (res_valid),
        .out       (res)
    );

    // A result leaving the pipeline goes to the output register, or to the spare
    // entry when the output register is holding a result that is not yet transferred.
    always_comb
    begin
        arrive          = en & res_valid;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !result.ready)
        begin
            if (arrive)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = arrive;
            out_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.hit   = out_data_reg.hit;
    assign result.hit_x = out_data_reg.hit_x;
    assign result.hit_y = out_data_reg.hit_y;
    assign result.hit_z = out_data_reg.hit_z;

endmodule

`default_nettype wire

@@ sim/rbi_tb_if.sv @@
// Testbench copy point for the channel interfaces: the interfaces themselves come from
// rtl/rbi_if.sv; this file holds the ray item type that the testbench queues.
// No dependencies.
`timescale 1ns / 100ps

package rbi_tb_pkg;

    typedef struct packed {
        logic [30:0] half_x;
        logic [30:0] half_y;
        logic [30:0] half_z;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] origin_z;
        logic [31:0] dir_x;
        logic [31:0] dir_y;
        logic [31:0] dir_z;
    } ray_item_t;

endpackage

@@ sim/ray_box_intersect_unit_tb.sv @@
// Self-checking testbench for ray_box_intersect_unit: drives rays with random gaps,
// predicts each hit result in fixed point and compares results in order.
// Depends on rbi_pkg, rbi_if, rbi_tb_pkg and the RTL.
`timescale 1ns / 100ps

module ray_box_intersect_unit_tb;

    localparam int FRAC = 16;
    localparam int LATENCY = 38;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rbi_ray_if ray ();
    rbi_hit_if result ();

    ray_box_intersect_unit #(.FRAC_BITS(FRAC)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .ray(ray),
        .result(result)
    );

    always #10 clk = ~clk;

    rbi_tb_pkg::ray_item_t pending_rays[$];
    rbi_pkg::result_t expected_hits[$];
    int mismatches = 0;
    longint cycles = 0;
    bit stim_done = 1'b0;
    bit hold_off = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;
    int n_queued = 0;
    int n_accepted = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d != 0) && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    // An arithmetic shift floors toward minus infinity, which is what the block does.
    function automatic rbi_pkg::result_t predict_hit(rbi_tb_pkg::ray_item_t r);
        longint half[3], org[3], dir[3], tv[3], c[3], face, v, absv;
        bit cand[3];
        bit in_box, hit;
        int w;
        rbi_pkg::result_t res;
        half[0] = r.half_x; half[1] = r.half_y; half[2] = r.half_z;
        org[0] = signed'(r.origin_x); org[1] = signed'(r.origin_y);
        org[2] = signed'(r.origin_z);
        dir[0] = signed'(r.dir_x); dir[1] = signed'(r.dir_y); dir[2] = signed'(r.dir_z);
        in_box = 1'b1;
        hit = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            tv[a] = -(64'sd1 << FRAC);
            cand[a] = 1'b0;
            c[a] = 0;
        end
        for (int a = 0; a < 3; a++)
        begin
            if (org[a] < -half[a] || org[a] > half[a])
            begin
                face = (org[a] < -half[a]) ? -half[a] : half[a];
                in_box = 1'b0;
                cand[a] = 1'b1;
                c[a] = face;
                if (dir[a] == 0)
                    hit = 1'b0;
                else
                    tv[a] = sat32(floor_div((face - org[a]) <<< FRAC, dir[a]));
            end
        end
        if (in_box)
        begin
            for (int a = 0; a < 3; a++)
                c[a] = org[a];
        end
        else if (hit)
        begin
            w = 0;
            if (tv[1] > tv[0])
                w = 1;
            if (tv[2] > tv[w])
                w = 2;
            if (!cand[w] || tv[w] < 0)
                hit = 1'b0;
            else
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (a != w)
                    begin
                        v = sat32((tv[w] * dir[a]) >>> FRAC);
                        v = sat32(org[a] + v);
                        absv = (v < 0) ? -v : v;
                        if (absv > half[a])
                            hit = 1'b0;
                        c[a] = v;
                    end
                end
            end
        end
        res.hit = hit;
        res.hit_x = hit ? c[0][31:0] : 32'd0;
        res.hit_y = hit ? c[1][31:0] : 32'd0;
        res.hit_z = hit ? c[2][31:0] : 32'd0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    task automatic add_ray(rbi_tb_pkg::ray_item_t r);
        pending_rays.insert(pending_rays.size(), r);
        n_queued++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] rand_coord(logic [30:0] half);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return {1'b0, half};
            2: return -{1'b0, half};
            3: return {1'b0, half} + 1;
            4: return -{1'b0, half} - 1;
            default: return $urandom_range(0, 2 * half) - half;
        endcase
    endfunction

    function automatic rbi_tb_pkg::ray_item_t rand_ray();
        rbi_tb_pkg::ray_item_t r;
        logic [31:0] tgt[3];
        logic [31:0] d[3];
        int ax;
        r.half_x = 31'(($urandom_range(0, 9) == 0) ? $urandom()
                                                    : $urandom_range(0, 32'h00100000));
        r.half_y = 31'(($urandom_range(0, 9) == 0) ? $urandom()
                                                    : $urandom_range(0, 32'h00100000));
        r.half_z = 31'(($urandom_range(0, 9) == 0) ? $urandom()
                                                    : $urandom_range(0, 32'h00100000));
        if ($urandom_range(0, 3) == 0)
        begin
            r.origin_x = rand_coord(r.half_x);
            r.origin_y = rand_coord(r.half_y);
            r.origin_z = rand_coord(r.half_z);
            r.dir_x = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom();
            r.dir_y = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom();
            r.dir_z = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom();
        end
        else
        begin
            // Aim at a point inside the box so that many rays hit.
            tgt[0] = $urandom_range(0, 2 * r.half_x) - r.half_x;
            tgt[1] = $urandom_range(0, 2 * r.half_y) - r.half_y;
            tgt[2] = $urandom_range(0, 2 * r.half_z) - r.half_z;
            for (int a = 0; a < 3; a++)
                d[a] = $signed($urandom_range(0, 32'h00040000)) - 32'sh00020000;
            ax = $urandom_range(0, 2);
            if (d[ax] == 0)
                d[ax] = 32'h00010000;
            r.dir_x = d[0]; r.dir_y = d[1]; r.dir_z = d[2];
            r.origin_x = tgt[0] - ($signed(d[0]) * 4);
            r.origin_y = tgt[1] - ($signed(d[1]) * 4);
            r.origin_z = tgt[2] - ($signed(d[2]) * 4);
            if ($urandom_range(0, 4) == 0)
            begin
                r.dir_x = -r.dir_x; r.dir_y = -r.dir_y; r.dir_z = -r.dir_z;
            end
        end
        return r;
    endfunction

    function automatic rbi_tb_pkg::ray_item_t make_ray(
        logic [31:0] hx, logic [31:0] hy, logic [31:0] hz,
        logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
        logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        rbi_tb_pkg::ray_item_t r;
        r.half_x = hx[30:0]; r.half_y = hy[30:0]; r.half_z = hz[30:0];
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        return r;
    endfunction

    initial
    begin
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] HMAX = 32'h7FFF_FFFF;
        // Inside, on a face, zero direction, behind, grazing and saturating rays.
        add_ray(make_ray(ONE, ONE, ONE, 0, 0, 0, ONE, 0, 0));
        add_ray(make_ray(ONE, ONE, ONE, ONE, -ONE, ONE, 0, 0, 0));
        add_ray(make_ray(ONE, ONE, ONE, -3 * ONE, 0, 0, ONE, 0, 0));
        add_ray(make_ray(ONE, ONE, ONE, 3 * ONE, 0, 0, ONE, 0, 0));
        add_ray(make_ray(ONE, ONE, ONE, 3 * ONE, 0, 0, 0, ONE, 0));
        add_ray(make_ray(ONE, ONE, ONE, 3 * ONE, 3 * ONE, 0, -ONE, -ONE, 0));
        add_ray(make_ray(ONE, ONE, ONE, 3 * ONE, 5 * ONE, 7 * ONE,
                         -ONE, -2 * ONE, -3 * ONE));
        add_ray(make_ray(ONE, ONE, ONE, -3 * ONE, 0, 0, ONE, 2 * ONE, 0));
        add_ray(make_ray(ONE, ONE, ONE, ONE + 1, 0, 0, -1, 0, 0));
        add_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_ray(make_ray(0, 0, 0, 1, 0, 0, -1, 0, 0));
        add_ray(make_ray(HMAX, HMAX, HMAX, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h8000_0000));
        add_ray(make_ray(0, HMAX, HMAX, 32'h8000_0000, 0, 0,
                         1, 32'h7FFF_FFFF, 32'h8000_0000));
        add_ray(make_ray(ONE, ONE, HMAX, 32'h8000_0000, 0, 0,
                         32'h7FFF_FFFF, 1, 32'h8000_0000));
        add_ray(make_ray(ONE, ONE, ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000));
        add_ray(make_ray(ONE, ONE, ONE, -2 * ONE, -2 * ONE, 0, ONE, ONE, 0));
        add_ray(make_ray(ONE, ONE, ONE, 0, 0, -5 * ONE, 1, -1, ONE));
        for (int i = 0; i < N_RANDOM / 2; i++)
            add_ray(rand_ray());
        // Let the pipeline drain completely once before the second half.
        wait (n_accepted == n_queued);
        hold_off = 1'b1;
        wait (expected_hits.size() == 0);
        hold_off = 1'b0;
        for (int i = 0; i < N_RANDOM / 2; i++)
            add_ray(rand_ray());
        wait (n_accepted == n_queued);
        stim_done = 1'b1;
    end

    // Ray driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray.valid <= 1'b0;
            {ray.half_x, ray.half_y, ray.half_z} <= '0;
            {ray.origin_x, ray.origin_y, ray.origin_z} <= '0;
            {ray.dir_x, ray.dir_y, ray.dir_z} <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (ray.valid && ray.ready)
            begin
                expected_hits.insert(expected_hits.size(),
                    predict_hit({ray.half_x, ray.half_y, ray.half_z, ray.origin_x,
                                 ray.origin_y, ray.origin_z, ray.dir_x, ray.dir_y,
                                 ray.dir_z}));
                n_accepted++;
            end
            if (!ray.valid || ray.ready)
            begin
                if (send_gap > 0)
                begin
                    ray.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_rays.size() > 0 && !hold_off)
                begin
                    rbi_tb_pkg::ray_item_t r;
                    r = pending_rays.pop_front();
                    ray.valid <= 1'b1;
                    {ray.half_x, ray.half_y, ray.half_z, ray.origin_x, ray.origin_y,
                     ray.origin_z, ray.dir_x, ray.dir_y, ray.dir_z} <= r;
                    send_gap <= pick_gap();
                end
                else
                    ray.valid <= 1'b0;
            end
        end
    end

    // Result monitor and stall generator.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    report_mismatch("unexpected result", {31'd0, result.hit}, 32'd0);
                end
                else
                begin
                    rbi_pkg::result_t want;
                    want = expected_hits.pop_front();
                    if (result.hit !== want.hit)
                        report_mismatch("hit", {31'd0, result.hit}, {31'd0, want.hit});
                    if (result.hit_x !== want.hit_x)
                        report_mismatch("hit_x", result.hit_x, want.hit_x);
                    if (result.hit_y !== want.hit_y)
                        report_mismatch("hit_y", result.hit_y, want.hit_y);
                    if (result.hit_z !== want.hit_z)
                        report_mismatch("hit_z", result.hit_z, want.hit_z);
                end
            end
            if (recv_gap > 0)
            begin
                result.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                result.ready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        wait (expected_hits.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
